// ===== hw/rtl/dda_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
package dda_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // x offsets of the extra pixels in triple mode
  localparam int PIX_OFF1 = 35;
  localparam int PIX_OFF2 = 70;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    PIX_BASE,
    PIX_OFF35,
    PIX_OFF70
  } pix_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     advance;
    pix_sel_e pix_sel;
  } dda_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;
    logic triple;
    logic done;
  } dda_stat_t;

endpackage

// ===== hw/rtl/dda_if.sv =====
// Valid/ready channel interfaces for line commands and pixel words.
interface dda_in_if #(
  parameter int CoordBits = dda_pkg::COORD_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [CoordBits-1:0] x_start;
  logic [CoordBits-1:0] y_start;
  logic [CoordBits-1:0] x_end;
  logic [CoordBits-1:0] y_end;
  logic                 triple;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, triple, input ready);
  modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, triple, output ready);
endinterface

interface dda_out_if #(
  parameter int CoordBits = dda_pkg::COORD_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [CoordBits:0]   pix_x;
  logic [CoordBits-1:0] pix_y;
  logic                 last_of_step;
  logic                 line_done;

  modport source (output valid, pix_x, pix_y, last_of_step, line_done, input ready);
  modport sink   (input valid, pix_x, pix_y, last_of_step, line_done, output ready);
endinterface

// ===== hw/rtl/dda_ctrl.sv =====
// Control state machine: load, increment division and pixel emission.
module dda_ctrl #(
  parameter int FracBits = dda_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  input  logic               out_ready_i,
  input  dda_pkg::dda_stat_t stat_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output logic               last_o,
  output dda_pkg::dda_cmd_t  cmd_o
);
  import dda_pkg::*;

  localparam int CntW = $clog2(FracBits + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e    state_q;
  logic [CntW-1:0] cnt_q;
  pix_sel_e  sel_q;
  logic      in_acc;
  logic      out_acc;
  logic      last_pix;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign last_pix    = !stat_i.triple || (sel_q == PIX_OFF70);
  assign last_o      = last_pix;

  assign cmd_o.load     = in_acc && (in_cmd_i == CMD_LOAD);
  assign cmd_o.div_step = (state_q == ST_DIV);
  assign cmd_o.advance  = out_acc && last_pix;
  assign cmd_o.pix_sel  = sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= PIX_BASE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_cmd_i == CMD_LOAD) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end else if (in_acc && stat_i.active) begin
            state_q <= ST_EMIT;
            sel_q   <= PIX_BASE;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(FracBits)) state_q <= ST_IDLE;
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (last_pix) begin
              state_q <= ST_IDLE;
            end else if (sel_q == PIX_BASE) begin
              sel_q <= PIX_OFF35;
            end else begin
              sel_q <= PIX_OFF70;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dda_datapath.sv =====
// Position, increment and step-count registers with a radix-2 divider.
module dda_datapath #(
  parameter int CoordBits = dda_pkg::COORD_BITS_DEF,
  parameter int FracBits  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dda_pkg::dda_cmd_t    cmd_i,
  input  logic [CoordBits-1:0] x_start_i,
  input  logic [CoordBits-1:0] y_start_i,
  input  logic [CoordBits-1:0] x_end_i,
  input  logic [CoordBits-1:0] y_end_i,
  input  logic                 triple_i,
  output dda_pkg::dda_stat_t   stat_o,
  output logic [CoordBits:0]   pix_x_o,
  output logic [CoordBits-1:0] pix_y_o
);
  import dda_pkg::*;

  localparam int PosW = CoordBits + FracBits;

  logic [PosW-1:0]      pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [FracBits:0]    qx_q, qy_q;          // increment magnitudes
  logic [CoordBits:0]   rx_q, ry_q;          // divider remainders
  logic [CoordBits-1:0] steps_q;
  logic [CoordBits:0]   steps_left_q;
  logic                 neg_x_q, neg_y_q, triple_q, active_q;

  logic [CoordBits-1:0] ax, ay, steps;
  logic                 gex, gey;
  logic [CoordBits:0]   subx, suby;
  logic [CoordBits:0]   int_x, offs;
  logic [PosW-1:0]      qx_ext, qy_ext;

  // absolute differences and major-axis length
  assign ax    = (x_end_i >= x_start_i) ? x_end_i - x_start_i : x_start_i - x_end_i;
  assign ay    = (y_end_i >= y_start_i) ? y_end_i - y_start_i : y_start_i - y_end_i;
  assign steps = (ax > ay) ? ax : ay;

  // one restoring division step per cycle for both axes
  assign gex  = rx_q >= {1'b0, steps_q};
  assign gey  = ry_q >= {1'b0, steps_q};
  assign subx = gex ? rx_q - {1'b0, steps_q} : rx_q;
  assign suby = gey ? ry_q - {1'b0, steps_q} : ry_q;

  assign qx_ext  = {{(PosW-FracBits-1){1'b0}}, qx_q};
  assign qy_ext  = {{(PosW-FracBits-1){1'b0}}, qy_q};
  assign pos_x_d = neg_x_q ? pos_x_q - qx_ext : pos_x_q + qx_ext;
  assign pos_y_d = neg_y_q ? pos_y_q - qy_ext : pos_y_q + qy_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      steps_left_q <= '0;
    end else if (cmd_i.load) begin
      active_q     <= 1'b1;
      steps_left_q <= {1'b0, steps} + 1'b1;
    end else if (cmd_i.advance) begin
      if (stat_o.done) begin
        active_q     <= 1'b0;
        steps_left_q <= '0;
      end else begin
        steps_left_q <= steps_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      rx_q     <= '0;
      ry_q     <= '0;
      qx_q     <= '0;
      qy_q     <= '0;
      steps_q  <= '0;
      triple_q <= 1'b0;
    end else if (cmd_i.load) begin
      pos_x_q  <= {x_start_i, {FracBits{1'b0}}};
      pos_y_q  <= {y_start_i, {FracBits{1'b0}}};
      neg_x_q  <= x_end_i < x_start_i;
      neg_y_q  <= y_end_i < y_start_i;
      rx_q     <= {1'b0, ax};
      ry_q     <= {1'b0, ay};
      qx_q     <= '0;
      qy_q     <= '0;
      steps_q  <= steps;
      triple_q <= triple_i;
    end else if (cmd_i.div_step) begin
      rx_q <= {subx[CoordBits-1:0], 1'b0};
      ry_q <= {suby[CoordBits-1:0], 1'b0};
      qx_q <= {qx_q[FracBits-1:0], gex};
      qy_q <= {qy_q[FracBits-1:0], gey};
    end else if (cmd_i.advance && !stat_o.done) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  always_comb begin
    unique case (cmd_i.pix_sel)
      PIX_OFF35: offs = (CoordBits+1)'(PIX_OFF1);
      PIX_OFF70: offs = (CoordBits+1)'(PIX_OFF2);
      default:   offs = '0;
    endcase
  end

  assign int_x   = {1'b0, pos_x_q[PosW-1:FracBits]};
  assign pix_x_o = int_x + offs;
  assign pix_y_o = pos_y_q[PosW-1:FracBits];

  assign stat_o.active = active_q;
  assign stat_o.triple = triple_q;
  assign stat_o.done   = (steps_left_q[CoordBits:1] == '0);

endmodule

// ===== hw/rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer.
// A load word (cmd 0) is accepted and then runs the increment division in the
// radix-2 divider, which produces one quotient bit per cycle for both axes;
// no word is taken meanwhile. A step word (cmd 1) is accepted and then
// delivers its pixel words, each held until the sink takes it: 1 pixel, or 3
// in triple mode. A step with no line loaded is dropped. Words are handled
// one at a time.
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  dda_in_if.sink   in_i,
  dda_out_if.source out_o
);
  import dda_pkg::*;

  dda_cmd_t  cmd;
  dda_stat_t st;

  dda_ctrl #(
    .FracBits (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .out_ready_i (out_o.ready),
    .stat_i      (st),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .last_o      (out_o.last_of_step),
    .cmd_o       (cmd)
  );

  dda_datapath #(
    .CoordBits (COORD_BITS),
    .FracBits  (FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .x_start_i (in_i.x_start),
    .y_start_i (in_i.y_start),
    .x_end_i   (in_i.x_end),
    .y_end_i   (in_i.y_end),
    .triple_i  (in_i.triple),
    .stat_o    (st),
    .pix_x_o   (out_o.pix_x),
    .pix_y_o   (out_o.pix_y)
  );

  assign out_o.line_done = st.done;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while pixel word pending");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.cmd == CMD_LOAD |=> !in_i.ready && !out_o.valid)
    else $error("load not followed by division");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.last_of_step && out_o.line_done |=> !st.active)
    else $error("line still active after final step");

  a_emit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> st.active)
    else $error("pixel word without an active line");

endmodule
